@@ sv/atulp_pkg.sv @@
// Shared types, constants and helper functions for the AT unsolicited line parser.
// Used by every module of the block; depends on nothing else.
package atulp_pkg;

    localparam int LINE_CAPACITY   = 256;
    localparam int SENDER_CAPACITY = 32;

    localparam int LCNT_W = $clog2(LINE_CAPACITY);
    localparam int SLEN_W = $clog2(SENDER_CAPACITY + 1);

    localparam logic signed [15:0] SIGNAL_RESET = 16'sd99;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_CMT,
        CLS_CREG,
        CLS_CGATT,
        CLS_CSQ,
        CLS_OTHER
    } line_class_t;

    typedef enum logic [2:0] {
        KIND_SENDER  = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_BODY    = 3'd2,
        KIND_END     = 3'd3,
        KIND_RESTART = 3'd4,
        KIND_STATUS  = 3'd5
    } kind_t;

    // Progress of the decimal field scan; the second field uses the upper copies.
    typedef enum logic [3:0] {
        NUM_START1  = 4'd0,
        NUM_SIGN1   = 4'd1,
        NUM_DIGITS1 = 4'd2,
        NUM_START2  = 4'd4,
        NUM_SIGN2   = 4'd5,
        NUM_DIGITS2 = 4'd6,
        NUM_FAIL    = 4'd7,
        NUM_DONE1   = 4'd8,
        NUM_DONE2   = 4'd9
    } num_phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data_byte;
        logic               sender_ok;
        logic               net_registered;
        logic               data_attached;
        logic signed [15:0] signal_level;
    } atulp_result_t;

    function automatic logic [63:0] prefix_text(line_class_t cls);
        logic [63:0] txt;
        unique case (cls)
            CLS_CMT:   txt = {"+CMT:", 24'h0};
            CLS_CREG:  txt = {"+CREG:", 16'h0};
            CLS_CGATT: txt = {"+CGATT:", 8'h0};
            CLS_CSQ:   txt = {"+CSQ:", 24'h0};
            default:   txt = 64'h0;
        endcase
        return txt;
    endfunction

    function automatic logic [7:0] prefix_char(line_class_t cls, logic [2:0] pos);
        logic [63:0] txt;
        logic [2:0]  idx;
        txt = prefix_text(cls);
        idx = 3'd7 - pos;
        return txt[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic [2:0] prefix_len(line_class_t cls);
        logic [2:0] len;
        unique case (cls)
            CLS_CMT:   len = 3'd5;
            CLS_CREG:  len = 3'd6;
            CLS_CGATT: len = 3'd7;
            CLS_CSQ:   len = 3'd5;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'd48) && (b <= 8'd57);
    endfunction

    // One decimal digit into a running value, clamped to the 16-bit range.
    function automatic logic signed [15:0] accumulate(logic signed [15:0] v,
                                                       logic [7:0] b, logic neg);
        logic signed [20:0] d;
        logic signed [20:0] v10;
        logic signed [20:0] r;
        logic signed [15:0] res;
        d   = $signed({13'd0, 8'(b - 8'd48)});
        v10 = 21'(v) * 21'sd10;
        r   = neg ? (v10 - d) : (v10 + d);
        if (r > 21'sd32767)
        begin
            res = 16'sh7FFF;
        end
        else if (r < -21'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = r[15:0];
        end
        return res;
    endfunction

    function automatic logic [1:0] number_count(num_phase_t ph);
        logic [1:0] n;
        case (ph) inside
            NUM_DIGITS1, NUM_START2, NUM_SIGN2, NUM_DONE1: n = 2'd1;
            NUM_DIGITS2, NUM_DONE2:                        n = 2'd2;
            default:                                       n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

@@ sv/at_unsolicited_line_parser.sv @@
// AT unsolicited result code line parser, top level.
// Instantiates atulp_input_stage, atulp_engine and atulp_output_stage; uses atulp_pkg.
//
// The slave stream carries one modem receive byte per word in s_axis_tdata[7:0].
// CR is dropped, LF ends a line and empty lines are ignored. +CMT: lines stream
// their quoted sender, then a header word, and the next line is streamed as SMS
// body followed by an end word (or a restart word on line overflow). +CREG:,
// +CGATT: and +CSQ: lines give a status word when their fields parse.
// The master stream carries the word kind in m_axis_tuser and the payload and
// current status in m_axis_tdata. A byte gives zero or one result word.
// A byte in the input register is processed once the result register is free,
// and its result word is then loaded into the result register.
// Throughput: one byte per cycle while the result register is free; the input
// register feeds a single pass of per-byte logic into the result register.
// When the receiver stalls with a result held, the engine waits and the input
// register takes at most one more byte before s_axis_tready drops.
// Reset clears the valid bits of both stream registers and the line state;
// the registered and attached flags go to zero and the signal level to 99.
module at_unsolicited_line_parser
    import atulp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [8] sender_ok,
                                        // [9] net_registered, [10] data_attached,
                                        // [26:11] signal_level, [31:27] zero
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);

    logic          byte_valid;
    logic [7:0]    byte_data;
    logic          out_free;
    logic          fire;
    logic          emit;
    atulp_result_t result;

    assign fire = byte_valid && out_free;

    atulp_input_stage u_input (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .consume       (fire),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data)
    );

    atulp_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .b      (byte_data),
        .emit   (emit),
        .result (result)
    );

    atulp_output_stage u_output (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (emit),
        .result        (result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ sv/atulp_input_stage.sv @@
// Input register of the line parser: holds one received byte until the engine takes it.
// Depends on atulp_pkg.
module atulp_input_stage
    import atulp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       consume,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign s_axis_tready = !valid_reg || consume;
    assign byte_valid    = valid_reg;
    assign byte_data     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            data_reg <= s_axis_tdata;
        end
    end

endmodule

@@ sv/atulp_engine.sv @@
// Per-byte line engine: line assembly, prefix match, sender and body streaming,
// decimal field scan and status flags. Depends on atulp_pkg.
module atulp_engine
    import atulp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    b,
    output logic          emit,
    output atulp_result_t result
);

    logic               awaiting_body_reg, awaiting_body_next;
    logic [LCNT_W-1:0]  line_count_reg, line_count_next;
    line_class_t        line_class_reg, line_class_next;
    logic [2:0]         prefix_pos_reg, prefix_pos_next;
    logic [1:0]         quote_phase_reg, quote_phase_next;
    logic [SLEN_W-1:0]  sender_len_reg, sender_len_next;
    num_phase_t         number_phase_reg, number_phase_next;
    logic               number_negative_reg, number_negative_next;
    logic signed [15:0] first_value_reg, first_value_next;
    logic signed [15:0] second_value_reg, second_value_next;
    logic               registered_reg, registered_next;
    logic               attached_reg, attached_next;
    logic signed [15:0] signal_reg, signal_next;

    logic               clear_line;
    kind_t              res_kind;
    logic [7:0]         res_data;
    logic               res_ok;
    logic [1:0]         num_cnt;

    assign num_cnt = number_count(number_phase_reg);

    always_comb
    begin
        awaiting_body_next   = awaiting_body_reg;
        line_count_next      = line_count_reg;
        line_class_next      = line_class_reg;
        prefix_pos_next      = prefix_pos_reg;
        quote_phase_next     = quote_phase_reg;
        sender_len_next      = sender_len_reg;
        number_phase_next    = number_phase_reg;
        number_negative_next = number_negative_reg;
        first_value_next     = first_value_reg;
        second_value_next    = second_value_reg;
        registered_next      = registered_reg;
        attached_next        = attached_reg;
        signal_next          = signal_reg;
        clear_line           = 1'b0;
        emit                 = 1'b0;
        res_kind             = KIND_SENDER;
        res_data             = 8'h00;
        res_ok               = 1'b0;

        if (fire && (b != CHAR_CR))
        begin
            if (b == CHAR_LF)
            begin
                clear_line = 1'b1;
                if (line_count_reg != '0)
                begin
                    if (awaiting_body_reg)
                    begin
                        awaiting_body_next = 1'b0;
                        emit               = 1'b1;
                        res_kind           = KIND_END;
                    end
                    else if ((line_class_reg != CLS_NONE) && (line_class_reg != CLS_OTHER)
                             && (prefix_pos_reg >= prefix_len(line_class_reg)))
                    begin
                        unique case (line_class_reg)
                            CLS_CMT:
                            begin
                                awaiting_body_next = 1'b1;
                                emit               = 1'b1;
                                res_kind           = KIND_HEADER;
                                res_ok             = (quote_phase_reg == 2'd2) &&
                                    (sender_len_reg <= SLEN_W'(SENDER_CAPACITY - 1));
                            end
                            CLS_CREG:
                            begin
                                if (num_cnt == 2'd2)
                                begin
                                    registered_next = (second_value_reg == 16'sd1) ||
                                                      (second_value_reg == 16'sd5);
                                    emit            = 1'b1;
                                    res_kind        = KIND_STATUS;
                                end
                            end
                            CLS_CGATT:
                            begin
                                if (num_cnt != 2'd0)
                                begin
                                    attached_next = (first_value_reg == 16'sd1);
                                    emit          = 1'b1;
                                    res_kind      = KIND_STATUS;
                                end
                            end
                            default:
                            begin
                                if (num_cnt != 2'd0)
                                begin
                                    signal_next = first_value_reg;
                                    emit        = 1'b1;
                                    res_kind    = KIND_STATUS;
                                end
                            end
                        endcase
                    end
                end
            end
            else if (line_count_reg == LCNT_W'(LINE_CAPACITY - 1))
            begin
                // Overflow: drop byte, restart line; restart word if anything streamed.
                clear_line = 1'b1;
                if (awaiting_body_reg ||
                    ((line_class_reg == CLS_CMT) && (sender_len_reg != '0)))
                begin
                    emit     = 1'b1;
                    res_kind = KIND_RESTART;
                end
            end
            else
            begin
                line_count_next = line_count_reg + 1'b1;
                if (awaiting_body_reg)
                begin
                    // A zero byte stops streaming for the rest of the body line.
                    if (line_class_reg == CLS_NONE)
                    begin
                        if (b == CHAR_NUL)
                        begin
                            line_class_next = CLS_OTHER;
                        end
                        else
                        begin
                            emit     = 1'b1;
                            res_kind = KIND_BODY;
                            res_data = b;
                        end
                    end
                end
                else
                begin
                    unique case (line_class_reg)
                        CLS_NONE:
                        begin
                            if (prefix_pos_reg < 3'd2)
                            begin
                                if (b == prefix_char(CLS_CMT, prefix_pos_reg))
                                begin
                                    prefix_pos_next = prefix_pos_reg + 3'd1;
                                end
                                else
                                begin
                                    line_class_next = CLS_OTHER;
                                end
                            end
                            else
                            begin
                                prefix_pos_next = 3'd3;
                                if (b == "M")
                                begin
                                    line_class_next = CLS_CMT;
                                end
                                else if (b == "R")
                                begin
                                    line_class_next = CLS_CREG;
                                end
                                else if (b == "G")
                                begin
                                    line_class_next = CLS_CGATT;
                                end
                                else if (b == "S")
                                begin
                                    line_class_next = CLS_CSQ;
                                end
                                else
                                begin
                                    line_class_next = CLS_OTHER;
                                end
                            end
                        end
                        CLS_OTHER:
                        begin
                        end
                        default:
                        begin
                            if (prefix_pos_reg < prefix_len(line_class_reg))
                            begin
                                if (b == prefix_char(line_class_reg, prefix_pos_reg))
                                begin
                                    prefix_pos_next = prefix_pos_reg + 3'd1;
                                end
                                else
                                begin
                                    line_class_next = CLS_OTHER;
                                end
                            end
                            else if (line_class_reg != CLS_CMT)
                            begin
                                unique case (number_phase_reg)
                                    NUM_START1, NUM_START2:
                                    begin
                                        if (is_space(b))
                                        begin
                                        end
                                        else if ((b == CHAR_PLUS) || (b == CHAR_MINUS))
                                        begin
                                            number_negative_next = (b == CHAR_MINUS);
                                            number_phase_next = (number_phase_reg == NUM_START1)
                                                ? NUM_SIGN1 : NUM_SIGN2;
                                        end
                                        else if (is_digit(b))
                                        begin
                                            number_negative_next = 1'b0;
                                            if (number_phase_reg == NUM_START1)
                                            begin
                                                first_value_next  = accumulate(16'sd0, b, 1'b0);
                                                number_phase_next = NUM_DIGITS1;
                                            end
                                            else
                                            begin
                                                second_value_next = accumulate(16'sd0, b, 1'b0);
                                                number_phase_next = NUM_DIGITS2;
                                            end
                                        end
                                        else
                                        begin
                                            number_phase_next = (number_phase_reg == NUM_START1)
                                                ? NUM_FAIL : NUM_DONE1;
                                        end
                                    end
                                    NUM_SIGN1, NUM_SIGN2:
                                    begin
                                        if (is_digit(b))
                                        begin
                                            if (number_phase_reg == NUM_SIGN1)
                                            begin
                                                first_value_next = accumulate(16'sd0, b,
                                                                              number_negative_reg);
                                                number_phase_next = NUM_DIGITS1;
                                            end
                                            else
                                            begin
                                                second_value_next = accumulate(16'sd0, b,
                                                                               number_negative_reg);
                                                number_phase_next = NUM_DIGITS2;
                                            end
                                        end
                                        else
                                        begin
                                            number_phase_next = (number_phase_reg == NUM_SIGN1)
                                                ? NUM_FAIL : NUM_DONE1;
                                        end
                                    end
                                    NUM_DIGITS1:
                                    begin
                                        if (is_digit(b))
                                        begin
                                            first_value_next = accumulate(first_value_reg, b,
                                                                          number_negative_reg);
                                        end
                                        else if ((line_class_reg == CLS_CREG) &&
                                                 (b == CHAR_COMMA))
                                        begin
                                            number_phase_next = NUM_START2;
                                        end
                                        else
                                        begin
                                            number_phase_next = NUM_DONE1;
                                        end
                                    end
                                    NUM_DIGITS2:
                                    begin
                                        if (is_digit(b))
                                        begin
                                            second_value_next = accumulate(second_value_reg, b,
                                                                           number_negative_reg);
                                        end
                                        else
                                        begin
                                            number_phase_next = NUM_DONE2;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            else
                            begin
                                // Sender field: quote phase 0 before, 1 inside, 2 closed,
                                // 3 cut short by a zero byte.
                                if (quote_phase_reg == 2'd0)
                                begin
                                    if (b == CHAR_QUOTE)
                                    begin
                                        quote_phase_next = 2'd1;
                                    end
                                    else if (b == CHAR_NUL)
                                    begin
                                        quote_phase_next = 2'd3;
                                    end
                                end
                                else if (quote_phase_reg == 2'd1)
                                begin
                                    if (b == CHAR_QUOTE)
                                    begin
                                        quote_phase_next = 2'd2;
                                    end
                                    else if (b == CHAR_NUL)
                                    begin
                                        quote_phase_next = 2'd3;
                                    end
                                    else if (sender_len_reg < SLEN_W'(SENDER_CAPACITY - 1))
                                    begin
                                        sender_len_next = sender_len_reg + 1'b1;
                                        emit            = 1'b1;
                                        res_kind        = KIND_SENDER;
                                        res_data        = b;
                                    end
                                    else
                                    begin
                                        sender_len_next = SLEN_W'(SENDER_CAPACITY);
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
        end

        if (clear_line)
        begin
            line_count_next      = '0;
            line_class_next      = CLS_NONE;
            prefix_pos_next      = 3'd0;
            quote_phase_next     = 2'd0;
            sender_len_next      = '0;
            number_phase_next    = NUM_START1;
            number_negative_next = 1'b0;
            first_value_next     = 16'sd0;
            second_value_next    = 16'sd0;
        end
    end

    always_comb
    begin
        result.kind           = res_kind;
        result.data_byte      = res_data;
        result.sender_ok      = res_ok;
        result.net_registered = registered_next;
        result.data_attached  = attached_next;
        result.signal_level   = signal_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_body_reg   <= 1'b0;
            line_count_reg      <= '0;
            line_class_reg      <= CLS_NONE;
            prefix_pos_reg      <= 3'd0;
            quote_phase_reg     <= 2'd0;
            sender_len_reg      <= '0;
            number_phase_reg    <= NUM_START1;
            number_negative_reg <= 1'b0;
            first_value_reg     <= 16'sd0;
            second_value_reg    <= 16'sd0;
            registered_reg      <= 1'b0;
            attached_reg        <= 1'b0;
            signal_reg          <= SIGNAL_RESET;
        end
        else
        begin
            awaiting_body_reg   <= awaiting_body_next;
            line_count_reg      <= line_count_next;
            line_class_reg      <= line_class_next;
            prefix_pos_reg      <= prefix_pos_next;
            quote_phase_reg     <= quote_phase_next;
            sender_len_reg      <= sender_len_next;
            number_phase_reg    <= number_phase_next;
            number_negative_reg <= number_negative_next;
            first_value_reg     <= first_value_next;
            second_value_reg    <= second_value_next;
            registered_reg      <= registered_next;
            attached_reg        <= attached_next;
            signal_reg          <= signal_next;
        end
    end

endmodule

@@ sv/atulp_output_stage.sv @@
// Result register of the line parser: holds one result word for the output stream.
// Depends on atulp_pkg.
module atulp_output_stage
    import atulp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  atulp_result_t result,
    output logic          free,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata,   // [7:0] data_byte, [8] sender_ok,
                                          // [9] net_registered, [10] data_attached,
                                          // [26:11] signal_level, [31:27] zero
    output logic [2:0]    m_axis_tuser    // [2:0] kind
);

    logic          valid_reg;
    atulp_result_t result_reg;

    assign free          = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = result_reg.kind;
    assign m_axis_tdata  = {5'd0, result_reg.signal_level, result_reg.data_attached,
                            result_reg.net_registered, result_reg.sender_ok,
                            result_reg.data_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule
